/* rtl/bst_pkg.sv */
// shared types and constants for the beacon score and track table
// no dependencies
package bst_pkg;
   localparam int MAX_ENTRIES = 32;
   localparam int RING_LEN = 24;
   localparam int PREFIX_COUNT = 10;
   localparam int SLOT_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int RING_W = $clog2(RING_LEN);
   localparam logic [6:0] SCORE_CAP = 7'd100;

   localparam logic [2:0] REG_PREFIX = 3'd0;
   localparam logic [2:0] REG_NAME = 3'd1;
   localparam logic [2:0] REG_MAKER = 3'd2;
   localparam logic [2:0] REG_MULTI = 3'd3;
   localparam logic [2:0] REG_ACCEPT = 3'd4;

   localparam logic [1:0] ST_IGNORED = 2'd0;
   localparam logic [1:0] ST_UPDATED = 2'd1;
   localparam logic [1:0] ST_ADDED = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   localparam logic [23:0] KNOWN_PREFIX [PREFIX_COUNT] = '{
      24'h588E81, 24'hCCCCCC, 24'hEC1BBD, 24'h9035EA, 24'h040D84,
      24'hF082C0, 24'h1C34F1, 24'h385B44, 24'h943469, 24'hB4E3F9};

   typedef struct packed {
      logic [47:0] address;
      logic        name_hit;
      logic        maker_seen;
      logic signed [7:0] strength;
      logic [31:0] stamp;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [6:0] score;
      logic [4:0] slot;
      logic       prefix_hit;
   } rsp_type;

   typedef struct packed {
      logic [47:0] address;
      logic        maker_seen;
      logic signed [7:0] strength;
      logic [31:0] stamp;
      logic [6:0]  score;
      logic        prefix_hit;
      logic        accept;
   } job_type;

   typedef struct packed {
      logic [6:0] score_prefix;
      logic [6:0] name_points;
      logic [6:0] score_maker;
      logic [6:0] bonus_points;
      logic [6:0] accept_level;
   } cfg_type;
endpackage

/* rtl/bst_front.sv */
// front end: prefix lookup, scoring and a two-word queue to the back end
// depends on bst_pkg
module bst_front import bst_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    job_valid,
   input  logic    job_ready,
   output job_type job_data
);
   job_type q_ff [2];
   job_type q_in;
   logic [1:0] cnt_ff;
   logic wr_ptr_ff, rd_ptr_ff;
   logic pfx;
   logic [1:0] nsig;
   logic [8:0] sum;
   logic [6:0] clamp;
   logic push, pop;

   always_comb begin
      pfx = 1'b0;
      for (int i = 0; i < PREFIX_COUNT; i++) begin
         if (req_data.address[47:24] == KNOWN_PREFIX[i]) pfx = 1'b1;
      end
      nsig = 2'(pfx) + 2'(req_data.name_hit) + 2'(req_data.maker_seen);
      sum = (pfx ? 9'(cfg.score_prefix) : 9'd0)
          + (req_data.name_hit ? 9'(cfg.name_points) : 9'd0)
          + (req_data.maker_seen ? 9'(cfg.score_maker) : 9'd0)
          + (nsig >= 2'd2 ? 9'(cfg.bonus_points) : 9'd0);
      clamp = (sum > 9'(SCORE_CAP)) ? SCORE_CAP : sum[6:0];
      q_in.address = req_data.address;
      q_in.maker_seen = req_data.maker_seen;
      q_in.strength = req_data.strength;
      q_in.stamp = req_data.stamp;
      q_in.score = clamp;
      q_in.prefix_hit = pfx;
      q_in.accept = clamp >= cfg.accept_level;
   end

   assign req_ready = cnt_ff != 2'd2;
   assign push = req_valid && req_ready;
   assign job_valid = cnt_ff != 2'd0;
   assign pop = job_valid && job_ready;
   assign job_data = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= q_in;
      if (reset) begin
         cnt_ff <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

/* rtl/bst_back.sv */
// back end: sequential table walk, entry update or insert, ring fill
// depends on bst_pkg
module bst_back import bst_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   output logic    job_ready,
   input  job_type job_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_FILL = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;
   localparam int RA_W = $clog2(MAX_ENTRIES * RING_LEN);

   logic [47:0] addr_mem [MAX_ENTRIES];
   logic [7:0]  str_mem [MAX_ENTRIES];
   logic [6:0]  score_mem [MAX_ENTRIES];
   logic [1:0]  flag_mem [MAX_ENTRIES];
   logic [31:0] time_mem [MAX_ENTRIES];
   logic [RING_W-1:0] head_mem [MAX_ENTRIES];
   logic [7:0]  ring_mem [MAX_ENTRIES * RING_LEN];

   logic [1:0] state_ff;
   job_type job_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] idx_ff;
   logic [RING_W-1:0] fill_ff;
   logic [47:0] rd_addr_ff;
   logic [RING_W-1:0] rd_head_ff;
   logic rd_ok_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   logic [SLOT_W-1:0] slot;
   logic [RA_W-1:0] ring_base;

   assign slot = idx_ff[SLOT_W-1:0];
   assign ring_base = RA_W'(slot) * RA_W'(RING_LEN);
   assign job_ready = state_ff == S_IDLE && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      rd_addr_ff <= addr_mem[slot];
      rd_head_ff <= head_mem[slot];
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (job_valid && job_ready) begin
                  job_ff <= job_data;
                  idx_ff <= '0;
                  rd_ok_ff <= 1'b0;
                  rsp_ff.score <= job_data.score;
                  rsp_ff.prefix_hit <= job_data.prefix_hit;
                  rsp_ff.slot <= '0;
                  rsp_ff.status <= ST_IGNORED;
                  state_ff <= job_data.accept ? S_WALK : S_DONE;
               end
            end
            S_WALK: begin
               if (!rd_ok_ff) begin
                  if (idx_ff >= count_ff) begin
                     if (count_ff >= CNT_W'(MAX_ENTRIES)) begin
                        rsp_ff.status <= ST_FULL;
                        state_ff <= S_DONE;
                     end else begin
                        addr_mem[slot] <= job_ff.address;
                        str_mem[slot] <= job_ff.strength;
                        score_mem[slot] <= job_ff.score;
                        flag_mem[slot] <= {job_ff.prefix_hit, job_ff.maker_seen};
                        time_mem[slot] <= job_ff.stamp;
                        head_mem[slot] <= '0;
                        count_ff <= count_ff + 1'b1;
                        fill_ff <= '0;
                        rsp_ff.status <= ST_ADDED;
                        rsp_ff.slot <= 5'(slot);
                        state_ff <= S_FILL;
                     end
                  end else begin
                     rd_ok_ff <= 1'b1;
                  end
               end else begin
                  rd_ok_ff <= 1'b0;
                  if (rd_addr_ff == job_ff.address) begin
                     str_mem[slot] <= job_ff.strength;
                     score_mem[slot] <= job_ff.score;
                     time_mem[slot] <= job_ff.stamp;
                     ring_mem[ring_base + RA_W'(rd_head_ff)] <= job_ff.strength;
                     head_mem[slot] <= (rd_head_ff == RING_W'(RING_LEN - 1)) ? '0
                                       : rd_head_ff + 1'b1;
                     rsp_ff.status <= ST_UPDATED;
                     rsp_ff.slot <= 5'(slot);
                     state_ff <= S_DONE;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            S_FILL: begin
               ring_mem[ring_base + RA_W'(fill_ff)] <= job_ff.strength;
               fill_ff <= fill_ff + 1'b1;
               if (fill_ff == RING_W'(RING_LEN - 1)) state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* rtl/beacon_score_and_track_table_top.sv */
// top level: register file, front scorer and back table walker
// ignored words skip the table walk; accepted words walk the table entry by entry,
// and a ring fill follows when an entry is added
// the back end takes one word at a time; the front queue holds two more
// synchronous active-high reset clears configuration to defaults and empties the table
// depends on bst_pkg, bst_front, bst_back
module beacon_score_and_track_table_top import bst_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [6:0] csr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);
   cfg_type cfg_ff;
   logic    job_valid, job_ready;
   job_type job_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{7'd15, 7'd45, 7'd60, 7'd20, 7'd40};
      end else if (csr_valid) begin
         case (csr_index)
            REG_PREFIX: cfg_ff.score_prefix <= csr_data;
            REG_NAME:   cfg_ff.name_points <= csr_data;
            REG_MAKER:  cfg_ff.score_maker <= csr_data;
            REG_MULTI:  cfg_ff.bonus_points <= csr_data;
            REG_ACCEPT: cfg_ff.accept_level <= csr_data;
            default: ;
         endcase
      end
   end

   bst_front u_front (
      .clock, .reset, .cfg(cfg_ff), .req_valid, .req_ready, .req_data,
      .job_valid, .job_ready, .job_data
   );

   bst_back u_back (
      .clock, .reset, .job_valid, .job_ready, .job_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   a_score_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.score <= SCORE_CAP)
      else $error("score above cap");
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_IGNORED || rsp_data.status == ST_FULL)
      |-> rsp_data.slot == 5'd0)
      else $error("slot set on ignored or full word");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped while stalled");
endmodule

/* test/tb_beacon_score_and_track_table_top.sv */
// testbench for beacon_score_and_track_table_top: scores adverts and tracks addresses
// a self-checking scoreboard predicts every verdict word; depends on bst_pkg and the rtl
`timescale 1ns / 100ps

module tb_beacon_score_and_track_table_top;
   import bst_pkg::*;

   class track_table_model;
      logic [6:0] weight_prefix = 7'd15, weight_name = 7'd45, weight_maker = 7'd60;
      logic [6:0] weight_multi = 7'd20, accept_level = 7'd40;
      logic [47:0] known_addr [MAX_ENTRIES];
      int unsigned entries = 0;
      rsp_type pending_verdicts [$];
      int mismatches = 0;

      function void set_reg(logic [2:0] idx, logic [6:0] val);
         case (idx)
            REG_PREFIX: weight_prefix = val;
            REG_NAME: weight_name = val;
            REG_MAKER: weight_maker = val;
            REG_MULTI: weight_multi = val;
            REG_ACCEPT: accept_level = val;
            default: ;
         endcase
      endfunction

      function void note_advert(req_type r);
         rsp_type v;
         int unsigned total, hits, i;
         bit found;
         total = 0;
         hits = 0;
         found = 0;
         v.prefix_hit = 1'b0;
         for (i = 0; i < PREFIX_COUNT; i++)
            if (KNOWN_PREFIX[i] == r.address[47:24]) v.prefix_hit = 1'b1;
         if (v.prefix_hit) begin total += weight_prefix; hits++; end
         if (r.name_hit) begin total += weight_name; hits++; end
         if (r.maker_seen) begin total += weight_maker; hits++; end
         if (hits >= 2) total += weight_multi;
         if (total > 100) total = 100;
         v.score = total[6:0];
         v.status = ST_IGNORED;
         v.slot = '0;
         if (total >= accept_level) begin
            for (i = 0; i < entries && !found; i++)
               if (known_addr[i] == r.address) begin
                  found = 1;
                  v.status = ST_UPDATED;
                  v.slot = i[4:0];
               end
            if (!found) begin
               if (entries >= MAX_ENTRIES) v.status = ST_FULL;
               else begin
                  known_addr[entries] = r.address;
                  v.status = ST_ADDED;
                  v.slot = entries[4:0];
                  entries++;
               end
            end
         end
         pending_verdicts.push_back(v);
      endfunction

      function void check_verdict(rsp_type got);
         rsp_type want;
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected verdict word %h", got);
            return;
         end
         want = pending_verdicts.pop_front();
         if (got.status !== want.status || got.score !== want.score ||
             got.slot !== want.slot || got.prefix_hit !== want.prefix_hit) begin
            mismatches++;
            if (mismatches <= 10)
               $display("verdict mismatch: expected st=%0d sc=%0d sl=%0d px=%0d, got st=%0d sc=%0d sl=%0d px=%0d",
                  want.status, want.score, want.slot, want.prefix_hit,
                  got.status, got.score, got.slot, got.prefix_hit);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic csr_valid = 0, csr_ready;
   logic [2:0] csr_index = '0;
   logic [6:0] csr_data = '0;
   logic req_valid = 0, req_ready;
   req_type req_data = '0;
   logic rsp_valid, rsp_ready = 0;
   rsp_type rsp_data;

   track_table_model tracker = new();
   logic [47:0] addr_pool [48];
   bit hold_request = 0;
   int unsigned cycles = 0;

   beacon_score_and_track_table_top dut (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (!reset && req_valid && req_ready) tracker.note_advert(req_data);
      if (!reset && rsp_valid && rsp_ready) tracker.check_verdict(rsp_data);
      if (!reset && csr_valid && csr_ready) tracker.set_reg(csr_index, csr_data);
   end

   // receiver: changing stall patterns plus one long hold-off on request
   initial begin
      int unsigned hold_left, mode, mode_left;
      hold_left = 0;
      mode = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request && hold_left == 0) begin
            hold_request = 0;
            hold_left = 400;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 300);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 0);
            2: rsp_ready <= ($urandom_range(0, 7) != 0);
            default: rsp_ready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   task automatic send_advert(req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   task automatic pause_sender(int unsigned n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after the last word
   task automatic write_reg(logic [2:0] idx, logic [6:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending_verdicts.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic req_type make_advert(logic [47:0] a, bit nm, bit mk);
      req_type r;
      r.address = a;
      r.name_hit = nm;
      r.maker_seen = mk;
      r.strength = 8'($urandom);
      r.stamp = $urandom;
      return r;
   endfunction

   function automatic req_type random_advert();
      if ($urandom_range(0, 3) != 0)
         return make_advert(addr_pool[$urandom_range(0, 47)], 1'($urandom), 1'($urandom));
      return make_advert(48'({$urandom, $urandom}), 1'($urandom), 1'($urandom));
   endfunction

   task automatic random_phase(int unsigned count, bit squeeze);
      int unsigned sent, burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && sent < count) begin
            send_advert(random_advert());
            sent++;
            burst--;
         end
         if (!squeeze && $urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 8));
      end
   endtask

   task automatic set_weights(logic [6:0] p, logic [6:0] n, logic [6:0] m,
                              logic [6:0] b, logic [6:0] acc);
      write_reg(REG_PREFIX, p);
      write_reg(REG_NAME, n);
      write_reg(REG_MAKER, m);
      write_reg(REG_MULTI, b);
      write_reg(REG_ACCEPT, acc);
      write_reg(3'd5 + 3'($urandom_range(0, 2)), 7'($urandom));
      csr_valid <= 1'b0;
   endtask

   initial begin
      req_type r;
      int i;
      for (i = 0; i < 48; i++) begin
         addr_pool[i] = 48'({$urandom, $urandom});
         if (i < 24) addr_pool[i][47:24] = KNOWN_PREFIX[i % PREFIX_COUNT];
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every prefix, flag combinations, field extremes, repeats
      for (i = 0; i < PREFIX_COUNT; i++)
         send_advert(make_advert({KNOWN_PREFIX[i], 24'h000000}, 1'(i % 2), i % 3 == 0));
      r = make_advert(48'h0, 1'b1, 1'b0); r.strength = -8'sd128; r.stamp = '0;
      send_advert(r);
      r = make_advert(48'hFFFF_FFFF_FFFF, 1'b0, 1'b1); r.strength = 8'sd127; r.stamp = '1;
      send_advert(r);
      send_advert(make_advert(48'hFFFF_FFFF_FFFF, 1'b1, 1'b1));
      send_advert(make_advert(48'h0, 1'b0, 1'b0));
      send_advert(make_advert(48'h0, 1'b1, 1'b1));
      send_advert(make_advert({24'h588E81, 24'hFFFFFF}, 1'b1, 1'b1));
      send_advert(make_advert({24'h588E81, 24'hFFFFFF}, 1'b0, 1'b0));
      send_advert(make_advert({24'hB4E3F9, 24'h123456}, 1'b1, 1'b1));
      drain();

      set_weights(7'd127, 7'd127, 7'd127, 7'd127, 7'd0);
      random_phase(270, 0);
      drain();
      set_weights(7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
      random_phase(270, 0);
      drain();
      set_weights(7'd30, 7'd30, 7'd30, 7'd30, 7'd100);
      hold_request = 1;
      random_phase(270, 1);
      drain();
      set_weights(7'd100, 7'd100, 7'd100, 7'd100, 7'd127);
      random_phase(270, 0);
      drain();
      set_weights(7'd15, 7'd45, 7'd60, 7'd20, 7'd40);
      random_phase(270, 0);
      drain();
      set_weights(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                  7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                  7'($urandom_range(0, 101)));
      random_phase(270, 0);
      drain();
      set_weights(7'($urandom_range(0, 60)), 7'($urandom_range(0, 60)),
                  7'($urandom_range(0, 60)), 7'($urandom_range(0, 60)),
                  7'($urandom_range(0, 60)));
      random_phase(240, 0);
      drain();

      if (tracker.mismatches == 0 && tracker.pending_verdicts.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
